[sv/nsm_pkg.sv]
package nsm_pkg;

    localparam int CHAR_W      = 8;
    localparam int NAME_CHARS  = 16;
    localparam int GUESS_CHARS = 14;
    // compare span: name plus two bytes of zero tail for the swap look-ahead
    localparam int SPAN        = NAME_CHARS + 2;
    localparam int POS_W       = 16;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam int WORD_W       = 64;
    localparam int GUESS_HIGH_W = 48;

    // grades
    localparam logic [2:0] GRADE_EXACT  = 3'd0;
    localparam logic [2:0] GRADE_SWAP   = 3'd1;
    localparam logic [2:0] GRADE_EDIT   = 3'd2;
    localparam logic [2:0] GRADE_PREFIX = 3'd3;
    localparam logic [2:0] GRADE_NONE   = 3'd4;

    // configuration register indexes
    localparam logic CFG_GUESS_LOW  = 1'b0;
    localparam logic CFG_GUESS_HIGH = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] name_chars_low;
        logic [WORD_W-1:0] name_chars_high;
        logic              entry_in_use;
        logic              new_search;
    } t_item;

    typedef struct packed {
        logic [2:0]       entry_distance;
        logic             found;
        logic [1:0]       best_distance;
        logic [POS_W-1:0] best_index;
        logic             search_done;
    } t_result;

    typedef struct packed {
        logic              index;
        logic [WORD_W-1:0] data;
    } t_cfg;

    // one graded entry handed from the grading stage to the scan tracker
    typedef struct packed {
        logic       valid;
        logic       entry_in_use;
        logic       new_search;
        logic [2:0] grade;
    } t_step;

endpackage

[sv/nsm_if.sv]
interface nsm_item_if;
    logic           valid;
    logic           ready;
    nsm_pkg::t_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface nsm_result_if;
    logic             valid;
    logic             ready;
    nsm_pkg::t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface nsm_cfg_if;
    logic          valid;
    logic          ready;
    nsm_pkg::t_cfg payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/nsm_grade.sv]
module nsm_grade (
    input  logic [nsm_pkg::WORD_W-1:0]       i_name_low,
    input  logic [nsm_pkg::WORD_W-1:0]       i_name_high,
    input  logic [nsm_pkg::WORD_W-1:0]       i_guess_low,
    input  logic [nsm_pkg::GUESS_HIGH_W-1:0] i_guess_high,
    output logic [2:0]                       o_grade
);

    localparam int SPAN   = nsm_pkg::SPAN;
    localparam int CHAR_W = nsm_pkg::CHAR_W;

    logic [2*nsm_pkg::WORD_W-1:0]                     name_vec;
    logic [nsm_pkg::WORD_W+nsm_pkg::GUESS_HIGH_W-1:0] guess_vec;
    logic [CHAR_W-1:0] nb [SPAN];
    logic [CHAR_W-1:0] gb [SPAN];
    logic [SPAN:0]     eq0;   // name[k..] == guess[k..]
    logic [SPAN:0]     eqn;   // name[k+1..] == guess[k..]
    logic [SPAN:0]     eqg;   // name[k..] == guess[k+1..]

    assign name_vec  = {i_name_high, i_name_low};
    assign guess_vec = {i_guess_high, i_guess_low};

    // strings end at the first zero byte
    always_comb begin
        logic live_n;
        logic live_g;
        live_n = 1'b1;
        live_g = 1'b1;
        for (int k = 0; k < SPAN; k++) begin
            nb[k] = '0;
            gb[k] = '0;
        end
        for (int k = 0; k < nsm_pkg::NAME_CHARS; k++) begin
            live_n = live_n & (name_vec[k*CHAR_W +: CHAR_W] != '0);
            nb[k]  = live_n ? name_vec[k*CHAR_W +: CHAR_W] : '0;
        end
        for (int k = 0; k < nsm_pkg::GUESS_CHARS; k++) begin
            live_g = live_g & (guess_vec[k*CHAR_W +: CHAR_W] != '0);
            gb[k]  = live_g ? guess_vec[k*CHAR_W +: CHAR_W] : '0;
        end
    end

    // suffix equality at the three alignments
    always_comb begin
        eq0       = '0;
        eqn       = '0;
        eqg       = '0;
        eq0[SPAN] = 1'b1;
        eqn[SPAN] = 1'b1;
        eqg[SPAN] = 1'b1;
        eqn[SPAN-1] = 1'b1;
        eqg[SPAN-1] = 1'b1;
        for (int k = SPAN - 1; k >= 0; k--) begin
            eq0[k] = eq0[k+1] & (nb[k] == gb[k]);
        end
        for (int k = SPAN - 2; k >= 0; k--) begin
            eqn[k] = eqn[k+1] & (nb[k+1] == gb[k]);
            eqg[k] = eqg[k+1] & (nb[k] == gb[k+1]);
        end
    end

    // grade decided at the first mismatching byte
    always_comb begin
        logic       hit;
        logic       swap;
        logic       edit;
        logic [2:0] cand;
        hit     = 1'b0;
        o_grade = nsm_pkg::GRADE_EXACT;
        for (int j = 0; j < nsm_pkg::NAME_CHARS; j++) begin
            swap = (nb[j] != '0) && (gb[j] != '0) && (nb[j+1] != '0) && (gb[j+1] != '0)
                && (nb[j] == gb[j+1]) && (gb[j] == nb[j+1]) && eq0[j+2];
            edit = ((nb[j] != '0) && (gb[j] != '0) && eq0[j+1])
                || ((nb[j] != '0) && eqn[j])
                || ((gb[j] != '0) && eqg[j]);
            if (j >= 3 && gb[j] == '0) begin
                cand = nsm_pkg::GRADE_PREFIX;
            end else if (swap) begin
                cand = nsm_pkg::GRADE_SWAP;
            end else if (edit) begin
                cand = nsm_pkg::GRADE_EDIT;
            end else begin
                cand = nsm_pkg::GRADE_NONE;
            end
            if (!hit && (nb[j] != gb[j])) begin
                hit     = 1'b1;
                o_grade = cand;
            end
        end
    end

endmodule

[sv/nsm_scan.sv]
module nsm_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nsm_pkg::t_step       i_step,
    output logic                 o_ready,
    nsm_result_if.source         o_result
);

    logic                        r_valid;
    nsm_pkg::t_result            r_result;
    logic [1:0]                  r_best_grade;
    logic                        r_match_seen;
    logic [nsm_pkg::POS_W-1:0]   r_best_pos;
    logic [nsm_pkg::POS_W-1:0]   r_count;
    logic                        r_exact_seen;

    logic [1:0]                  n_best_grade;
    logic                        n_match_seen;
    logic [nsm_pkg::POS_W-1:0]   n_best_pos;
    logic [nsm_pkg::POS_W-1:0]   n_count;
    logic                        n_exact_seen;
    logic [2:0]                  g;
    logic                        fire;

    assign o_ready = !r_valid || o_result.ready;
    assign fire    = i_step.valid && o_ready;

    always_comb begin
        logic [nsm_pkg::POS_W-1:0] pos;
        if (i_step.new_search) begin
            n_best_grade = nsm_pkg::GRADE_PREFIX[1:0];
            n_match_seen = 1'b0;
            n_best_pos   = '0;
            pos          = '0;
            n_exact_seen = 1'b0;
        end else begin
            n_best_grade = r_best_grade;
            n_match_seen = r_match_seen;
            n_best_pos   = r_best_pos;
            pos          = r_count;
            n_exact_seen = r_exact_seen;
        end
        g = (i_step.entry_in_use && !n_exact_seen) ? i_step.grade : nsm_pkg::GRADE_NONE;
        if (g != nsm_pkg::GRADE_NONE && (!n_match_seen || g[1:0] <= n_best_grade)) begin
            n_best_grade = g[1:0];
            n_best_pos   = pos;
            n_match_seen = 1'b1;
            if (g == nsm_pkg::GRADE_EXACT) begin
                n_exact_seen = 1'b1;
            end
        end
        n_count = (pos == nsm_pkg::POS_MAX) ? pos : pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_best_grade <= nsm_pkg::GRADE_PREFIX[1:0];
            r_match_seen <= 1'b0;
            r_best_pos   <= '0;
            r_count      <= '0;
            r_exact_seen <= 1'b0;
        end else begin
            if (fire) begin
                r_valid      <= 1'b1;
                r_best_grade <= n_best_grade;
                r_match_seen <= n_match_seen;
                r_best_pos   <= n_best_pos;
                r_count      <= n_count;
                r_exact_seen <= n_exact_seen;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result.entry_distance <= g;
            r_result.found          <= n_match_seen;
            r_result.best_distance  <= n_best_grade;
            r_result.best_index     <= n_best_pos;
            r_result.search_done    <= n_exact_seen;
        end
    end

    assign o_result.valid   = r_valid;
    assign o_result.payload = r_result;

endmodule

[sv/name_spelling_match_top.sv]
// Input register, then result register. Throughput: one entry per cycle while the
// result is accepted; the entry name is graded by parallel byte compares in a single
// pass and the scan state is a small register updated on the same edge.
// Reset (i_rst_n low, synchronous): pipeline emptied, guess cleared to the empty
// string, scan state back to no match, best grade 3, position counter 0.
module name_spelling_match_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    nsm_item_if.sink     i_item,
    nsm_cfg_if.sink      i_cfg,
    nsm_result_if.source o_result
);

    // guess string registers, byte 0 in the low bits
    logic [nsm_pkg::WORD_W-1:0]       r_guess_low;
    logic [nsm_pkg::GUESS_HIGH_W-1:0] r_guess_high;

    // input stage
    logic           r_s1_valid;
    nsm_pkg::t_item r_s1_item;

    logic           scan_ready;
    logic [2:0]     grade;
    nsm_pkg::t_step step;

    // config writes are always taken; the user must do them only while the block is idle (unchecked by the block)
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guess_low  <= '0;
            r_guess_high <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.index)
                nsm_pkg::CFG_GUESS_LOW: begin
                    r_guess_low <= i_cfg.payload.data;
                end
                nsm_pkg::CFG_GUESS_HIGH: begin
                    r_guess_high <= i_cfg.payload.data[nsm_pkg::GUESS_HIGH_W-1:0];
                end
                default: begin
                    r_guess_low <= r_guess_low;
                end
            endcase
        end
    end

    // Input stage: refills whenever the entry it holds moves on to the result
    // register; the input stalls only while both registers are full and the
    // result is not taken.
    assign i_item.ready = !r_s1_valid || scan_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_s1_item <= i_item.payload;
        end
    end

    // Grading: first mismatching byte picks exact, swap, one edit, prefix or none.
    nsm_grade u_grade (
        .i_name_low   (r_s1_item.name_chars_low),
        .i_name_high  (r_s1_item.name_chars_high),
        .i_guess_low  (r_guess_low),
        .i_guess_high (r_guess_high),
        .o_grade      (grade)
    );

    assign step.valid        = r_s1_valid;
    assign step.entry_in_use = r_s1_item.entry_in_use;
    assign step.new_search   = r_s1_item.new_search;
    assign step.grade        = grade;

    // Scan tracker: best grade, its position, the saturating entry counter and
    // the early-stop flag, updated as the entry enters the result register.
    nsm_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_ready  (scan_ready),
        .o_result (o_result)
    );

endmodule
